/* design/lcdms_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcdms_pkg
// Shared types and timing constants for the LCD mode sequencer.
// ============================================================================
package lcdms_pkg;

    // Timing of one frame, in dot-clock ticks and lines.
    localparam int OAM_ENTRIES       = 40;
    localparam int DRAW_TICKS        = 93;
    localparam int HBLANK_TICKS      = 284;
    localparam int VBLANK_LINE_TICKS = 456;
    localparam int VISIBLE_LINES     = 144;
    localparam int VBLANK_LINES      = 10;

    // Field and register widths.
    localparam int CD_W     = 9;
    localparam int SCAN_W   = 6;
    localparam int LINE_W   = 8;
    localparam int MODE_W   = 2;
    localparam int EN_W     = 4;
    localparam int CFG_DW   = 8;
    localparam int CFG_AW   = 1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_LINE_COMPARE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_STAT_ENABLES = 1'b1;

    // Bits of the STAT interrupt enable register.
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_COIN   = 3;

    localparam logic [LINE_W-1:0] LAST_VISIBLE_END = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] FRAME_END        = LINE_W'(VISIBLE_LINES + VBLANK_LINES);

    // Display mode, also the state of the sequencer.
    typedef enum logic [MODE_W-1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    // View of the sequencer after the current beat has been applied.
    typedef struct packed {
        t_mode              mode;
        logic [LINE_W-1:0]  line;
        logic               vblank_irq;
        logic               frame_done;
    } t_view;

endpackage

/* design/lcdms_tick_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcdms_tick_if
// Input channel: each beat is one dot-clock tick or a hold.
// ============================================================================
interface lcdms_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

/* design/lcdms_res_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcdms_res_if
// Result channel: mode, line, coincidence and interrupt pulses per beat.
// ============================================================================
interface lcdms_res_if;
    import lcdms_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] current_line;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;

    modport source (output valid, output mode, output current_line, output coincidence,
                    output stat_irq, output vblank_irq, output frame_done, input ready);
    modport sink   (input valid, input mode, input current_line, input coincidence,
                    input stat_irq, input vblank_irq, input frame_done, output ready);
endinterface

/* design/lcd_mode_sequencer_stat_irq.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcd_mode_sequencer_stat_irq
// LCD mode sequencer with LY==LYC coincidence and STAT/VBLANK interrupts.
// ============================================================================
// Output: a result beat is offered in the cycle after its tick is accepted.
// Throughput: one tick beat per cycle; the output register is refilled in the
//   same cycle it is drained, so the input stalls only while the output stalls.
// Reset: synchronous, active low; starts in OAM scan on line 0, configuration
//   registers cleared, no result pending.
module lcd_mode_sequencer_stat_irq
    import lcdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    lcdms_tick_if.sink        i_tick_ch,
    lcdms_res_if.source       o_res
);

    logic [LINE_W-1:0] r_line_compare;
    logic [EN_W-1:0]   r_stat_en;
    logic              r_can_fire, n_can_fire;
    logic              r_valid;
    t_mode             r_mode;
    logic [LINE_W-1:0] r_line;
    logic              r_coin, r_stat, r_vbl, r_done;

    logic  accept, adv, found, coin, stat;
    t_view view;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare <= '0;
            r_stat_en      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_COMPARE: r_line_compare <= i_cfg_data;
                CFG_STAT_ENABLES: r_stat_en      <= i_cfg_data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept whenever the result register is empty or drains this cycle.
    assign i_tick_ch.ready = !r_valid || o_res.ready;
    assign accept          = i_tick_ch.valid && i_tick_ch.ready;
    assign adv             = accept && i_tick_ch.tick;

    lcdms_timing u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .o_view  (view)
    );

    // Coincidence and enabled STAT conditions on the advanced mode and line.
    assign coin  = (view.line == r_line_compare);
    assign found = (r_stat_en[EN_COIN]   && coin) ||
                   (r_stat_en[EN_OAM]    && view.mode == MODE_OAM) ||
                   (r_stat_en[EN_VBLANK] && view.mode == MODE_VBLANK) ||
                   (r_stat_en[EN_HBLANK] && view.mode == MODE_HBLANK);
    assign stat  = adv && found && r_can_fire;
    // Once a tick has no active condition, the next active one may fire.
    assign n_can_fire = adv ? !found : r_can_fire;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_can_fire <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            r_can_fire <= n_can_fire;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= view.mode;
            r_line <= view.line;
            r_coin <= coin;
            r_stat <= stat;
            r_vbl  <= view.vblank_irq;
            r_done <= view.frame_done;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.mode         = r_mode;
    assign o_res.current_line = r_line;
    assign o_res.coincidence  = r_coin;
    assign o_res.stat_irq     = r_stat;
    assign o_res.vblank_irq   = r_vbl;
    assign o_res.frame_done   = r_done;

endmodule

/* design/lcdms_timing.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcdms_timing
// Mode and line sequencer: OAM scan, drawing, HBLANK and VBLANK timing.
// ============================================================================
module lcdms_timing
    import lcdms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    output t_view o_view
);

    t_mode             r_mode,  n_mode;
    logic [LINE_W-1:0] r_line,  n_line;
    logic [CD_W-1:0]   r_cd,    n_cd;
    logic [SCAN_W-1:0] r_scan,  n_scan;
    logic              n_vbl, n_done;

    logic [CD_W-1:0]   cd_dec;
    logic [LINE_W-1:0] line_inc;
    logic [SCAN_W:0]   scan_inc;

    assign cd_dec   = r_cd - CD_W'(1);
    assign line_inc = r_line + LINE_W'(1);
    assign scan_inc = {1'b0, r_scan} + (SCAN_W + 1)'(1);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OAM;
            r_line <= '0;
            r_cd   <= '0;
            r_scan <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_cd   <= n_cd;
            r_scan <= n_scan;
        end
    end

    // Next mode, line and countdown for one dot-clock tick.
    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_cd   = r_cd;
        n_scan = r_scan;
        n_vbl  = 1'b0;
        n_done = 1'b0;
        case (r_mode)
            MODE_OAM: begin
                if (r_cd != '0) begin
                    n_cd = cd_dec;
                end else if (scan_inc >= (SCAN_W + 1)'(OAM_ENTRIES)) begin
                    n_scan = '0;
                    n_cd   = CD_W'(DRAW_TICKS);
                    n_mode = MODE_DRAW;
                end else begin
                    n_scan = scan_inc[SCAN_W-1:0];
                    n_cd   = CD_W'(1);
                end
            end
            MODE_DRAW: begin
                n_cd = cd_dec;
                if (cd_dec == '0) begin
                    n_mode = MODE_HBLANK;
                    n_cd   = CD_W'(HBLANK_TICKS);
                end
            end
            MODE_HBLANK: begin
                n_cd = cd_dec;
                if (cd_dec == '0) begin
                    n_line = line_inc;
                    if (line_inc == LAST_VISIBLE_END) begin
                        n_vbl  = 1'b1;
                        n_mode = MODE_VBLANK;
                        n_cd   = CD_W'(VBLANK_LINE_TICKS);
                    end else begin
                        n_mode = MODE_OAM;
                        n_cd   = '0;
                        n_scan = '0;
                    end
                end
            end
            default: begin
                n_cd = cd_dec;
                if (cd_dec == '0) begin
                    n_line = line_inc;
                    n_cd   = CD_W'(VBLANK_LINE_TICKS);
                    if (line_inc == FRAME_END) begin
                        n_done = 1'b1;
                        n_line = '0;
                        n_mode = MODE_OAM;
                        n_cd   = '0;
                        n_scan = '0;
                    end
                end
            end
        endcase
    end

    // Post-beat view: advanced state on a tick, present state otherwise.
    always_comb begin
        if (i_adv) begin
            o_view.mode       = n_mode;
            o_view.line       = n_line;
            o_view.vblank_irq = n_vbl;
            o_view.frame_done = n_done;
        end else begin
            o_view.mode       = r_mode;
            o_view.line       = r_line;
            o_view.vblank_irq = 1'b0;
            o_view.frame_done = 1'b0;
        end
    end

endmodule

/* design/lcdms_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcdms_checker
// Port-level checks of the mode sequencer, bound to the top level.
// ============================================================================
module lcdms_checker
    import lcdms_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [MODE_W-1:0] i_mode,
    input logic [LINE_W-1:0] i_line,
    input logic              i_vbl,
    input logic              i_done
);

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // The VBLANK pulse comes with VBLANK mode on the first VBLANK line.
    a_vbl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_vbl |-> i_mode == MODE_VBLANK && i_line == LAST_VISIBLE_END)
        else $error("vblank pulse outside vblank entry");

    // Frame end returns to OAM scan on line 0.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done |-> i_mode == MODE_OAM && i_line == '0 && !i_vbl)
        else $error("frame end without wrap to line 0");

    // The line never passes the last VBLANK line.
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_line < FRAME_END)
        else $error("line out of range");

endmodule

bind lcd_mode_sequencer_stat_irq lcdms_checker u_lcdms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_mode      (o_res.mode),
    .i_line      (o_res.current_line),
    .i_vbl       (o_res.vblank_irq),
    .i_done      (o_res.frame_done)
);

/* verif/lcd_mode_sequencer_stat_irq_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcd_mode_sequencer_stat_irq_test
// Self-checking bench for the LCD mode sequencer and its STAT/VBLANK pulses.
// Tick beats go in with random holds and gaps. A scoreboard class steps its
// own copy of the mode timing for every accepted tick and compares each
// result beat field by field. Phases with different compare lines and
// interrupt enables run the sequencer through OAM scan, drawing and HBLANK
// of the first few lines.
// ============================================================================
module lcd_mode_sequencer_stat_irq_test;
    import lcdms_pkg::*;

    // One expected or observed result beat.
    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              coin;
        logic              stat;
        logic              vbl;
        logic              done;
    } t_lcd_beat;

    // Scoreboard: steps the display timing for each accepted tick and keeps
    // the beats the block still owes.
    class lcd_timing_board;
        t_lcd_beat         expected_beats[$];
        int                mismatch_count;
        int                beats_seen;
        t_mode             mode_q;
        logic [LINE_W-1:0] line_q;
        logic [CD_W-1:0]   cd_q;
        logic [SCAN_W-1:0] scan_q;
        logic              can_fire_q;
        logic [LINE_W-1:0] lc_q;
        logic [EN_W-1:0]   en_q;

        function new();
            mismatch_count = 0;
            beats_seen     = 0;
            mode_q         = MODE_OAM;
            line_q         = '0;
            cd_q           = '0;
            scan_q         = '0;
            can_fire_q     = 1'b1;
            lc_q           = '0;
            en_q           = '0;
        endfunction

        // Print one line per mismatch; printing stops after a while so a
        // broken block cannot flood the log, but every mismatch is counted.
        task report(string what);
            if (mismatch_count < 200) begin
                $display("MISMATCH at result beat %0d: %s", beats_seen, what);
            end
            mismatch_count++;
        endtask

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_LINE_COMPARE) begin
                lc_q = data;
            end else begin
                en_q = data[EN_W-1:0];
            end
        endfunction

        // Advance the mode timing by one tick (or hold), then work out the
        // STAT condition from the new mode and line.
        function void note_tick(logic tick);
            t_lcd_beat b;
            logic      hit;
            b = '0;
            if (tick) begin
                case (mode_q)
                    MODE_OAM: begin
                        if (cd_q != 0) begin
                            cd_q = cd_q - 1'b1;
                        end else if (int'(scan_q) + 1 >= OAM_ENTRIES) begin
                            scan_q = '0;
                            cd_q   = CD_W'(DRAW_TICKS);
                            mode_q = MODE_DRAW;
                        end else begin
                            scan_q = scan_q + 1'b1;
                            cd_q   = CD_W'(1);
                        end
                    end
                    MODE_DRAW: begin
                        cd_q = cd_q - 1'b1;
                        if (cd_q == 0) begin
                            mode_q = MODE_HBLANK;
                            cd_q   = CD_W'(HBLANK_TICKS);
                        end
                    end
                    MODE_HBLANK: begin
                        cd_q = cd_q - 1'b1;
                        if (cd_q == 0) begin
                            line_q = line_q + 1'b1;
                            if (line_q == LINE_W'(VISIBLE_LINES)) begin
                                b.vbl  = 1'b1;
                                mode_q = MODE_VBLANK;
                                cd_q   = CD_W'(VBLANK_LINE_TICKS);
                            end else begin
                                mode_q = MODE_OAM;
                                cd_q   = '0;
                                scan_q = '0;
                            end
                        end
                    end
                    default: begin
                        cd_q = cd_q - 1'b1;
                        if (cd_q == 0) begin
                            line_q = line_q + 1'b1;
                            cd_q   = CD_W'(VBLANK_LINE_TICKS);
                            if (line_q == LINE_W'(VISIBLE_LINES + VBLANK_LINES)) begin
                                b.done = 1'b1;
                                line_q = '0;
                                mode_q = MODE_OAM;
                                cd_q   = '0;
                                scan_q = '0;
                            end
                        end
                    end
                endcase
                hit = (en_q[EN_COIN]   && line_q == lc_q)        ||
                      (en_q[EN_OAM]    && mode_q == MODE_OAM)    ||
                      (en_q[EN_VBLANK] && mode_q == MODE_VBLANK) ||
                      (en_q[EN_HBLANK] && mode_q == MODE_HBLANK);
                // The pulse fires only on the first active tick after a
                // tick with no enabled condition.
                if (hit && can_fire_q) begin
                    can_fire_q = 1'b0;
                    b.stat     = 1'b1;
                end
                if (!hit) begin
                    can_fire_q = 1'b1;
                end
            end
            b.mode = mode_q;
            b.line = line_q;
            b.coin = (line_q == lc_q);
            expected_beats.push_back(b);
        endfunction

        task check_beat(t_lcd_beat got);
            t_lcd_beat exp;
            if (expected_beats.size() == 0) begin
                report("result beat with no tick waiting for it");
            end else begin
                exp = expected_beats.pop_front();
                if (got.mode !== exp.mode)
                    report($sformatf("mode got %0d expected %0d", got.mode, exp.mode));
                if (got.line !== exp.line)
                    report($sformatf("line got %0d expected %0d", got.line, exp.line));
                if (got.coin !== exp.coin)
                    report($sformatf("coincidence got %0b expected %0b", got.coin, exp.coin));
                if (got.stat !== exp.stat)
                    report($sformatf("stat_irq got %0b expected %0b", got.stat, exp.stat));
                if (got.vbl !== exp.vbl)
                    report($sformatf("vblank_irq got %0b expected %0b", got.vbl, exp.vbl));
                if (got.done !== exp.done)
                    report($sformatf("frame_done got %0b expected %0b", got.done, exp.done));
            end
            beats_seen++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    lcdms_tick_if tick_ch ();
    lcdms_res_if  res_ch ();

    lcd_timing_board board;

    // Shared between the tick driver and the result sink.
    bit no_idle;
    bit res_hold_req;

    lcd_mode_sequencer_stat_irq u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick_ch  (tick_ch),
        .o_res      (res_ch)
    );

    // Clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("lcd_mode_sequencer_stat_irq regression: fail");
        $finish;
    end

    // Sample both channels at the edge; a tick is noted before its result
    // can appear, since the block registers the result.
    always @(posedge i_clk) begin
        if (i_rst_n && board != null) begin
            if (tick_ch.valid && tick_ch.ready) begin
                board.note_tick(tick_ch.tick);
            end
            if (res_ch.valid && res_ch.ready) begin
                board.check_beat('{mode: t_mode'(res_ch.mode), line: res_ch.current_line,
                                   coin: res_ch.coincidence, stat: res_ch.stat_irq,
                                   vbl: res_ch.vblank_irq, done: res_ch.frame_done});
            end
        end
    end

    // Result sink: random back-pressure, and on request one long hold-off
    // so that the output register fills and the tick input stalls.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_hold_req) begin
                res_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                for (int k = 0; k < 400; k++) @(posedge i_clk);
            end else begin
                res_ch.ready <= no_idle || ($urandom_range(99) >= 13);
            end
        end
    end

    // Offer one tick beat, after an optional random gap, and wait for it
    // to be taken.
    task send_tick(logic tick);
        if (!no_idle) begin
            while ($urandom_range(99) < 13) begin
                tick_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tick;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // Stop offering and wait until every owed result beat has come back.
    task drain_results(int limit_cycles);
        int waited;
        waited = 0;
        tick_ch.valid <= 1'b0;
        while (board.expected_beats.size() != 0 && waited < limit_cycles) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges while the block is idle.
    task configure(logic [LINE_W-1:0] lc, logic [EN_W-1:0] en);
        drain_results(5000);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LINE_COMPARE;
        i_cfg_data <= lc;
        @(posedge i_clk);
        board.set_reg(CFG_LINE_COMPARE, lc);
        i_cfg_idx  <= CFG_STAT_ENABLES;
        i_cfg_data <= CFG_DW'(en);
        @(posedge i_clk);
        board.set_reg(CFG_STAT_ENABLES, CFG_DW'(en));
        i_cfg_we   <= 1'b0;
    endtask

    // One phase of random ticks and holds; tick_pct sets the share of ticks.
    task run_phase(logic [LINE_W-1:0] lc, logic [EN_W-1:0] en, int n_items,
                   int tick_pct, bit steady, int stall_at);
        configure(lc, en);
        no_idle = steady;
        for (int i = 0; i < n_items; i++) begin
            if (i == stall_at) begin
                res_hold_req = 1'b1;
            end
            send_tick($urandom_range(99) < tick_pct);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic [3:0] reset_ticks;
        reset_ticks = 4'b0110;
        board        = new();
        no_idle      = 1'b0;
        res_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_LINE_COMPARE;
        i_cfg_data    <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.tick  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: holds and ticks straight out of reset, with the reset
        // configuration still in place.
        for (int i = 0; i < 4; i++) begin
            send_tick(reset_ticks[i]);
        end
        send_tick(1'b0);
        send_tick(1'b1);

        // All enables on at line 0: coincidence and OAM scan both active,
        // so only the first tick may pulse STAT; holds must not re-arm it.
        configure(8'd0, 4'hF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // Only coincidence enabled, on a line not yet reached: no pulse;
        // then only OAM enabled, which re-fires after the quiet ticks.
        configure(8'd255, 4'h8);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        configure(8'd0, 4'h4);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // Random part. The later phases are tick-heavy so the sequencer
        // leaves OAM scan, draws and reaches HBLANK and the next lines.
        run_phase(8'd0,   4'hF, 300, 60, 1'b0, -1);
        run_phase(8'd1,   4'h8, 200, 95, 1'b1, -1);
        run_phase(8'd255, 4'h1, 300, 97, 1'b0, 100);
        run_phase(8'd2,   4'h2, 200, 97, 1'b0, -1);
        run_phase(8'd3,   4'hF, 100, 97, 1'b0, -1);
        run_phase(LINE_W'($urandom_range(153, 0)), EN_W'($urandom_range(15, 0)),
                  200, 97, 1'b0, 50);
        run_phase(8'd0,   4'h0, 30,  50, 1'b0, -1);

        drain_results(5000);
        while (board.expected_beats.size() != 0) begin
            void'(board.expected_beats.pop_front());
            board.report("expected result beat never arrived");
        end
        if (board.mismatch_count == 0) begin
            $display("lcd_mode_sequencer_stat_irq regression: pass");
        end else begin
            $display("lcd_mode_sequencer_stat_irq regression: fail");
        end
        $finish;
    end

endmodule
